// ----- hw/rtl/tepq_pkg.sv -----
// shared types and constants for the timed event priority queue
`timescale 1ns / 1ps

package tepq_pkg;

	// field widths
	localparam int TICK_W     = 64;
	localparam int DATA_W     = 64;
	localparam int ORDER_W    = 64;
	localparam int TAG_W      = 8;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 8;

	// parameter defaults
	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_TAG_BITS    = 8;

	// most events fired by one advance
	localparam int MAX_FIRE   = 16;
	localparam int FIRE_CNT_W = $clog2(MAX_FIRE + 1);

	// opcodes
	localparam logic OP_SCHEDULE = 1'b0;
	localparam logic OP_ADVANCE  = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TIMELINE_ENABLE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRE_ENABLE     = 8'd1;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_SCHEDULED = 2'd0,
		ST_DROPPED   = 2'd1,
		ST_FIRED     = 2'd2,
		ST_NOTHING   = 2'd3
	} status_t;

	// stored event, less its tag
	typedef struct packed {
		logic [TICK_W-1:0]  due;
		logic [ORDER_W-1:0] order;
		logic [DATA_W-1:0]  data;
	} entry_t;

	// command broadcast to every slot of the chain
	typedef struct packed {
		logic   insert;
		logic   pop;
		entry_t ent;
	} slot_ctrl_t;

endpackage

// ----- hw/rtl/timed_event_priority_queue_top.sv -----
// top level of the timed event priority queue
`timescale 1ns / 1ps
//
// Timed event queue kept sorted by due tick, first in first out among equal
// due ticks, in a chain of QUEUE_DEPTH slots with the earliest event at slot 0.
// Input stream s_*: tuser is the opcode (schedule or advance), tdata carries
// delta, now, target, tag and user data. Output stream m_*: tuser is the
// status, tdata carries fired tag, data and lateness, tlast marks the final
// result of an input beat. The cfg channel writes timeline_enable (index 0)
// and fire_enable (index 1); write it only while the queue is idle.
// A schedule beat is accepted in the idle state; then, in the exec state, every
// slot compares its key with the new one and the later slots shift right.
// An advance beat yields one result per exec step; each fired
// event pops slot 0 and shifts the chain left. At most 16 events fire per
// advance. One beat is in work at a time; the next beat is accepted while
// the last result still waits in the output register.
// Reset empties the chain, clears the sequence counter and both enables.
// A stalled m_tready holds the output register and the chain stops.
//

module timed_event_priority_queue_top #(
	parameter int QUEUE_DEPTH = tepq_pkg::DEF_QUEUE_DEPTH,
	parameter int TAG_BITS    = tepq_pkg::DEF_TAG_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// delta[63:0], now[127:64], target[191:128],
	// event_tag[199:192], user_data[263:200]
	input  logic [263:0]                  s_tdata,
	// opcode[0]
	input  logic                          s_tuser,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// fired_tag[7:0], fired_data[71:8], lateness[135:72]
	output logic [135:0]                  m_tdata,
	// status[1:0]
	output logic [tepq_pkg::STATUS_W-1:0] m_tuser,
	output logic                          m_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tepq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic                          cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;

	// configuration
	logic timeline_en_q;
	logic fire_en_q;

	// item under work
	logic                          op_q;
	logic [tepq_pkg::TICK_W-1:0]   due_q;
	logic [tepq_pkg::TICK_W-1:0]   target_q;
	logic [TAG_BITS-1:0]           tag_q;
	logic [tepq_pkg::DATA_W-1:0]   data_q;
	logic [tepq_pkg::ORDER_W-1:0]  next_order_q;
	logic [tepq_pkg::FIRE_CNT_W-1:0] fire_cnt_q;

	// output register
	logic                          m_valid_q;
	tepq_pkg::status_t             m_status_q;
	logic [tepq_pkg::TAG_W-1:0]    m_tag_q;
	logic [tepq_pkg::DATA_W-1:0]   m_data_q;
	logic [tepq_pkg::TICK_W-1:0]   m_late_q;
	logic                          m_last_q;

	// chain wiring
	tepq_pkg::entry_t    slot_ent   [QUEUE_DEPTH];
	logic [TAG_BITS-1:0] slot_tag   [QUEUE_DEPTH];
	logic                slot_valid [QUEUE_DEPTH];
	logic                slot_gt    [QUEUE_DEPTH];
	tepq_pkg::slot_ctrl_t ctrl;

	logic                        in_beat;
	logic                        out_free;
	logic                        step;
	logic [tepq_pkg::TICK_W-1:0] sum;
	logic                        full;
	logic                        can_fire;
	logic                        more;

	assign in_beat  = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free = !m_valid_q || m_tready;
	assign step     = (state_q == ST_EXEC) && out_free;

	// due tick as now plus delta, clamped at zero on capture when the sum goes negative
	assign sum = s_tdata[127:64] + s_tdata[63:0];

	assign full = slot_valid[QUEUE_DEPTH-1];
	assign can_fire = slot_valid[0] && (slot_ent[0].due <= target_q);
	assign more = slot_valid[1] && (slot_ent[1].due <= target_q) &&
		(fire_cnt_q != tepq_pkg::FIRE_CNT_W'(tepq_pkg::MAX_FIRE - 1));

	// chain command
	always_comb begin
		ctrl.ent.due   = due_q;
		ctrl.ent.order = next_order_q;
		ctrl.ent.data  = data_q;
		ctrl.insert = step && timeline_en_q && (op_q == tepq_pkg::OP_SCHEDULE) && !full;
		ctrl.pop    = step && timeline_en_q && (op_q == tepq_pkg::OP_ADVANCE) &&
			fire_en_q && can_fire;
	end

	// slot chain
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
		tepq_pkg::entry_t    l_ent;
		logic [TAG_BITS-1:0] l_tag;
		logic                l_valid;
		logic                l_gt;
		tepq_pkg::entry_t    r_ent;
		logic [TAG_BITS-1:0] r_tag;
		logic                r_valid;

		if (i == 0) begin : g_head
			assign l_ent   = ctrl.ent;
			assign l_tag   = tag_q;
			assign l_valid = 1'b0;
			assign l_gt    = 1'b0;
		end else begin : g_body
			assign l_ent   = slot_ent[i-1];
			assign l_tag   = slot_tag[i-1];
			assign l_valid = slot_valid[i-1];
			assign l_gt    = slot_gt[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign r_ent   = ctrl.ent;
			assign r_tag   = tag_q;
			assign r_valid = 1'b0;
		end else begin : g_inner
			assign r_ent   = slot_ent[i+1];
			assign r_tag   = slot_tag[i+1];
			assign r_valid = slot_valid[i+1];
		end

		tepq_slot #(
			.TAG_BITS(TAG_BITS)
		) u_slot (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_tag    (tag_q),
			.left_ent   (l_ent),
			.left_tag   (l_tag),
			.left_valid (l_valid),
			.left_gt    (l_gt),
			.right_ent  (r_ent),
			.right_tag  (r_tag),
			.right_valid(r_valid),
			.ent        (slot_ent[i]),
			.tag        (slot_tag[i]),
			.valid      (slot_valid[i]),
			.gt         (slot_gt[i])
		);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeline_en_q <= 1'b0;
			fire_en_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tepq_pkg::REG_TIMELINE_ENABLE: timeline_en_q <= cfg_data;
				tepq_pkg::REG_FIRE_ENABLE:     fire_en_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (in_beat) begin
			op_q     <= s_tuser;
			due_q    <= sum[tepq_pkg::TICK_W-1] ? '0 : sum;
			target_q <= s_tdata[191:128];
			tag_q    <= TAG_BITS'(s_tdata[199:192]);
			data_q   <= s_tdata[263:200];
		end
	end

	// control: state, sequence counter, fire count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			next_order_q <= '0;
			fire_cnt_q   <= '0;
		end else begin
			if (ctrl.insert) begin
				next_order_q <= next_order_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					fire_cnt_q <= '0;
					if (in_beat) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (step) begin
						if (ctrl.pop && more) begin
							fire_cnt_q <= fire_cnt_q + 1'b1;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (step) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (step) begin
			m_tag_q    <= '0;
			m_data_q   <= '0;
			m_late_q   <= '0;
			m_last_q   <= 1'b1;
			m_status_q <= tepq_pkg::ST_NOTHING;
			if (ctrl.insert) begin
				m_status_q <= tepq_pkg::ST_SCHEDULED;
			end else if (timeline_en_q && (op_q == tepq_pkg::OP_SCHEDULE)) begin
				m_status_q <= tepq_pkg::ST_DROPPED;
			end else if (ctrl.pop) begin
				m_status_q <= tepq_pkg::ST_FIRED;
				m_tag_q    <= tepq_pkg::TAG_W'(slot_tag[0]);
				m_data_q   <= slot_ent[0].data;
				m_late_q   <= target_q - slot_ent[0].due;
				m_last_q   <= !more;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {m_late_q, m_data_q, m_tag_q};

endmodule

// ----- hw/rtl/tepq_slot.sv -----
// one slot of the sorted shift chain: holds an event, shifts on insert or pop
`timescale 1ns / 1ps

module tepq_slot #(
	parameter int TAG_BITS = tepq_pkg::DEF_TAG_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tepq_pkg::slot_ctrl_t ctrl,
	input  logic [TAG_BITS-1:0] new_tag,
	input  tepq_pkg::entry_t    left_ent,
	input  logic [TAG_BITS-1:0] left_tag,
	input  logic                left_valid,
	input  logic                left_gt,
	input  tepq_pkg::entry_t    right_ent,
	input  logic [TAG_BITS-1:0] right_tag,
	input  logic                right_valid,
	output tepq_pkg::entry_t    ent,
	output logic [TAG_BITS-1:0] tag,
	output logic                valid,
	output logic                gt
);

	tepq_pkg::entry_t    ent_q;
	logic [TAG_BITS-1:0] tag_q;
	logic                valid_q;

	// new event sorts ahead of this slot (empty slots sort last)
	assign gt = !valid_q || (ctrl.ent.due < ent_q.due) ||
		((ctrl.ent.due == ent_q.due) && (ctrl.ent.order < ent_q.order));

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.pop) begin
			valid_q <= right_valid;
		end else if (ctrl.insert && gt) begin
			valid_q <= left_gt ? left_valid : 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			ent_q <= right_ent;
			tag_q <= right_tag;
		end else if (ctrl.insert && gt) begin
			if (left_gt) begin
				ent_q <= left_ent;
				tag_q <= left_tag;
			end else begin
				ent_q <= ctrl.ent;
				tag_q <= new_tag;
			end
		end
	end

	assign ent   = ent_q;
	assign tag   = tag_q;
	assign valid = valid_q;

endmodule
